FILE: hw/rtl/dual_fenwick_weighted_prefix_sum_macros.svh
// Assertion macros used by dfwps_checker.sv.
`ifndef DUAL_FENWICK_WEIGHTED_PREFIX_SUM_MACROS_SVH
`define DUAL_FENWICK_WEIGHTED_PREFIX_SUM_MACROS_SVH

// Checked outside reset only.
`define DFWPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked during reset as well.
`define DFWPS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/dfwps_pkg.sv
`default_nettype none
package dfwps_pkg;

   localparam int KIND_WIDTH  = 2;
   localparam int POS_WIDTH   = 12;
   localparam int DELTA_WIDTH = 32;
   localparam int SUM_WIDTH   = 64;
   // signed delta times unsigned position
   localparam int PROD_WIDTH  = DELTA_WIDTH + POS_WIDTH + 1;

   localparam logic [KIND_WIDTH-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR = 2'd2;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_ZERO_POS = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;        // item accepted: capture operands, zero sums
      logic add_mode;    // adder takes the item operands
      logic accumulate;  // adder result goes into the sums
   } accum_ctrl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/dfwps_ram.sv
`default_nettype none
module dfwps_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dfwps_accum.sv
`default_nettype none
module dfwps_accum (
   input  wire logic                                 clock,
   input  wire dfwps_pkg::accum_ctrl_type            ctrl,
   input  wire logic signed [dfwps_pkg::DELTA_WIDTH-1:0] delta,
   input  wire logic [dfwps_pkg::POS_WIDTH-1:0]      position,
   input  wire logic [dfwps_pkg::SUM_WIDTH-1:0]      rd_count,
   input  wire logic [dfwps_pkg::SUM_WIDTH-1:0]      rd_weight,
   output logic      [dfwps_pkg::SUM_WIDTH-1:0]      sum_count,
   output logic      [dfwps_pkg::SUM_WIDTH-1:0]      sum_weight,
   output logic      [dfwps_pkg::SUM_WIDTH-1:0]      acc_count,
   output logic      [dfwps_pkg::SUM_WIDTH-1:0]      acc_weight
);

   localparam int SW = dfwps_pkg::SUM_WIDTH;
   localparam int PW = dfwps_pkg::PROD_WIDTH;
   localparam int DW = dfwps_pkg::DELTA_WIDTH;

   logic signed [PW-1:0] prod;
   logic [SW-1:0] d_ff, d_in;
   logic [SW-1:0] w_ff, w_in;
   logic [SW-1:0] acc_c_ff, acc_c_in;
   logic [SW-1:0] acc_w_ff, acc_w_in;
   logic [SW-1:0] op_c, op_w;

   assign prod = delta * $signed({1'b0, position});

   // one shared adder pair: tree update in add walks, running sum in queries
   assign op_c       = ctrl.add_mode ? d_ff : acc_c_ff;
   assign op_w       = ctrl.add_mode ? w_ff : acc_w_ff;
   assign sum_count  = rd_count + op_c;
   assign sum_weight = rd_weight + op_w;

   always_comb begin
      d_in     = d_ff;
      w_in     = w_ff;
      acc_c_in = acc_c_ff;
      acc_w_in = acc_w_ff;
      if (ctrl.load) begin
         d_in     = {{(SW-DW){delta[DW-1]}}, delta};
         w_in     = {{(SW-PW){prod[PW-1]}}, prod};
         acc_c_in = '0;
         acc_w_in = '0;
      end else if (ctrl.accumulate) begin
         acc_c_in = sum_count;
         acc_w_in = sum_weight;
      end
   end

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      w_ff     <= w_in;
      acc_c_ff <= acc_c_in;
      acc_w_ff <= acc_w_in;
   end

   assign acc_count  = acc_c_ff;
   assign acc_weight = acc_w_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dual_fenwick_weighted_prefix_sum.sv
`default_nettype none
// Two Fenwick trees over positions 1..TREE_SIZE-1 sharing one RAM row per position.
// Input channel req_*: kind (add, query, clear), position, signed delta.
// Result channel rsp_*: one item per input item with count_sum, weighted_sum, status.
// Add puts delta into the count tree and delta*position into the weighted tree;
// query returns both prefix sums up to position (saturated to TREE_SIZE-1);
// add at position zero changes nothing and returns status 1. Sums wrap at 64 bits.
// An add or query walks one tree level per cycle through the RAM port and one
// 64-bit adder pair, visiting at most log2(TREE_SIZE) levels (12 for 4096),
// then loads the result register once it is free; the result shows and
// req_ready comes back in the same cycle. A clear item sweeps the RAM, one row
// per cycle, and then returns its result through the same register.
// Reset runs the same sweep over all TREE_SIZE rows with req_ready low and no result.
// rsp_* sits in an output register; the block accepts the next item while it
// waits, and a finished item holds in place until that register is free.
module dual_fenwick_weighted_prefix_sum #(
   parameter int TREE_SIZE = 4096
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic [dfwps_pkg::KIND_WIDTH-1:0]         req_kind,
   input  wire logic [dfwps_pkg::POS_WIDTH-1:0]          req_position,
   input  wire logic signed [dfwps_pkg::DELTA_WIDTH-1:0] req_delta,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed [dfwps_pkg::SUM_WIDTH-1:0]        rsp_count_sum,
   output logic signed [dfwps_pkg::SUM_WIDTH-1:0]        rsp_weighted_sum,
   output logic                                          rsp_status
);

   localparam int AW = $clog2(TREE_SIZE);
   localparam int CW = AW + 1;
   localparam int XW = (CW > dfwps_pkg::POS_WIDTH) ? CW : dfwps_pkg::POS_WIDTH;
   localparam int SW = dfwps_pkg::SUM_WIDTH;

   dfwps_pkg::state_type      state_ff, state_in;
   dfwps_pkg::accum_ctrl_type ctrl;

   logic [AW-1:0] idx_ff, idx_in;
   logic          walk_add_ff, walk_add_in;
   logic          clr_resp_ff, clr_resp_in;
   logic          st_ff, st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_c_ff, rsp_w_ff;
   logic          rsp_st_ff;
   logic          load_rsp;

   logic [XW-1:0]   pos_x;
   logic [AW-1:0]   qstart;
   logic [CW-1:0]   add_next;
   logic [AW-1:0]   query_next;

   logic            wr_en;
   logic [AW-1:0]   rd_addr;
   logic [2*SW-1:0] wr_data, rd_data;
   logic [SW-1:0]   sum_count, sum_weight, acc_count, acc_weight;

   assign pos_x  = XW'(req_position);
   assign qstart = (pos_x > XW'(TREE_SIZE - 1)) ? AW'(TREE_SIZE - 1) : AW'(req_position);
   // climb: add lowest set bit; descend: drop lowest set bit
   assign add_next   = {1'b0, idx_ff} + {1'b0, idx_ff & (~idx_ff + AW'(1))};
   assign query_next = idx_ff & (idx_ff - AW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfwps_pkg::ST_CLEAR;
         idx_ff       <= '0;
         walk_add_ff  <= 1'b0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         walk_add_ff  <= walk_add_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (load_rsp) begin
         rsp_c_ff  <= acc_count;
         rsp_w_ff  <= acc_weight;
         rsp_st_ff <= st_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      walk_add_in = walk_add_ff;
      clr_resp_in = clr_resp_ff;
      st_in       = st_ff;
      ctrl        = '0;
      req_ready   = 1'b0;
      load_rsp    = 1'b0;
      wr_en       = 1'b0;
      wr_data     = {sum_weight, sum_count};
      rd_addr     = idx_ff;

      case (state_ff)
         dfwps_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            idx_in  = idx_ff + AW'(1);
            if (idx_ff == AW'(TREE_SIZE - 1)) begin
               idx_in   = '0;
               state_in = clr_resp_ff ? dfwps_pkg::ST_FINISH : dfwps_pkg::ST_IDLE;
            end
         end
         dfwps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load   = 1'b1;
               st_in       = dfwps_pkg::STATUS_DONE;
               clr_resp_in = 1'b0;
               state_in    = dfwps_pkg::ST_FINISH;
               case (req_kind)
                  dfwps_pkg::KIND_ADD: begin
                     if (req_position == '0) begin
                        st_in = dfwps_pkg::STATUS_ZERO_POS;
                     end else if (pos_x < XW'(TREE_SIZE)) begin
                        idx_in      = AW'(req_position);
                        rd_addr     = AW'(req_position);
                        walk_add_in = 1'b1;
                        state_in    = dfwps_pkg::ST_WALK;
                     end
                  end
                  dfwps_pkg::KIND_QUERY: begin
                     if (qstart != '0) begin
                        idx_in      = qstart;
                        rd_addr     = qstart;
                        walk_add_in = 1'b0;
                        state_in    = dfwps_pkg::ST_WALK;
                     end
                  end
                  dfwps_pkg::KIND_CLEAR: begin
                     idx_in      = '0;
                     clr_resp_in = 1'b1;
                     state_in    = dfwps_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = dfwps_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         dfwps_pkg::ST_WALK: begin
            // rd_data holds the row at idx_ff
            if (walk_add_ff) begin
               ctrl.add_mode = 1'b1;
               wr_en         = 1'b1;
               if (add_next >= CW'(TREE_SIZE)) begin
                  state_in = dfwps_pkg::ST_FINISH;
               end else begin
                  idx_in  = AW'(add_next);
                  rd_addr = AW'(add_next);
               end
            end else begin
               ctrl.accumulate = 1'b1;
               if (query_next == '0) begin
                  state_in = dfwps_pkg::ST_FINISH;
               end else begin
                  idx_in  = query_next;
                  rd_addr = query_next;
               end
            end
         end
         dfwps_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = dfwps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dfwps_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   dfwps_ram #(
      .WIDTH (2 * SW),
      .DEPTH (TREE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dfwps_accum u_accum (
      .clock      (clock),
      .ctrl       (ctrl),
      .delta      (req_delta),
      .position   (req_position),
      .rd_count   (rd_data[SW-1:0]),
      .rd_weight  (rd_data[2*SW-1:SW]),
      .sum_count  (sum_count),
      .sum_weight (sum_weight),
      .acc_count  (acc_count),
      .acc_weight (acc_weight)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_sum    = $signed(rsp_c_ff);
   assign rsp_weighted_sum = $signed(rsp_w_ff);
   assign rsp_status       = rsp_st_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dfwps_checker.sv
`default_nettype none
`include "dual_fenwick_weighted_prefix_sum_macros.svh"
module dfwps_checker (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     req_valid,
   input wire logic                                     req_ready,
   input wire logic                                     rsp_valid,
   input wire logic                                     rsp_ready,
   input wire logic signed [dfwps_pkg::SUM_WIDTH-1:0]   rsp_count_sum,
   input wire logic signed [dfwps_pkg::SUM_WIDTH-1:0]   rsp_weighted_sum,
   input wire logic                                     rsp_status
);

   // reset starts the clearing sweep: nothing accepted, nothing shown
   `DFWPS_ASSERT_RST(a_reset_quiet, reset |=> !req_ready && !rsp_valid, "busy after reset")

   // one item at a time: busy right after an accept
   `DFWPS_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "accepted back to back")

   // the zero-position flag never carries sums
   `DFWPS_ASSERT(a_flag_zero_sums, rsp_valid && rsp_status |-> rsp_count_sum == '0 && rsp_weighted_sum == '0, "flag with sums")

   `DFWPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_sum) && $stable(rsp_weighted_sum) && $stable(rsp_status), "stalled item changed")

endmodule

bind dual_fenwick_weighted_prefix_sum dfwps_checker u_checker (.*);
`default_nettype wire

FILE: tb/sv/dual_fenwick_weighted_prefix_sum_checker.sv
module dual_fenwick_weighted_prefix_sum_checker
   import dfwps_pkg::*;
#(
   parameter int TREE_SIZE = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [KIND_WIDTH-1:0]         req_kind,
   input  logic [POS_WIDTH-1:0]          req_position,
   input  logic signed [DELTA_WIDTH-1:0] req_delta,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SUM_WIDTH-1:0]   rsp_count_sum,
   input  logic signed [SUM_WIDTH-1:0]   rsp_weighted_sum,
   input  logic                          rsp_status,
   output int                            fail_count,
   output int                            outstanding
);

   typedef struct packed {
      logic [SUM_WIDTH-1:0] count_sum;
      logic [SUM_WIDTH-1:0] weighted_sum;
      logic                 status;
   } prefix_sums_type;

   longint unsigned count_bit[TREE_SIZE];
   longint unsigned weight_bit[TREE_SIZE];
   prefix_sums_type expected_sums_q[$];
   int              mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void clear_trees();
      for (int i = 0; i < TREE_SIZE; i++) begin
         count_bit[i]  = '0;
         weight_bit[i] = '0;
      end
   endfunction

   // applies one item to the shadow trees and returns the sums it yields
   function automatic prefix_sums_type fenwick_step(input logic [KIND_WIDTH-1:0] kind,
                                                    input logic [POS_WIDTH-1:0] pos,
                                                    input logic signed [DELTA_WIDTH-1:0] delta);
      prefix_sums_type res;
      int unsigned     p;
      longint unsigned d;
      longint unsigned w;
      res = '0;
      p   = pos;
      d   = longint'(delta);
      case (kind)
         KIND_ADD: begin
            if (p == 0) begin
               res.status = STATUS_ZERO_POS;
            end else begin
               w = d * longint'(p);
               while (p < TREE_SIZE) begin
                  count_bit[p]  += d;
                  weight_bit[p] += w;
                  p += p & (~p + 1);
               end
            end
         end
         KIND_QUERY: begin
            if (p > TREE_SIZE - 1) p = TREE_SIZE - 1;
            while (p != 0) begin
               res.count_sum    += count_bit[p];
               res.weighted_sum += weight_bit[p];
               p &= p - 1;
            end
         end
         KIND_CLEAR: clear_trees();
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      prefix_sums_type want;
      if (reset) begin
         expected_sums_q.delete();
         clear_trees();
      end else begin
         if (req_valid && req_ready)
            expected_sums_q.push_back(fenwick_step(req_kind, req_position, req_delta));
         if (rsp_valid && rsp_ready) begin
            if (expected_sums_q.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               want = expected_sums_q.pop_front();
               if (rsp_count_sum !== want.count_sum)
                  report_mismatch($sformatf("count_sum expected %h got %h",
                                            want.count_sum, rsp_count_sum));
               if (rsp_weighted_sum !== want.weighted_sum)
                  report_mismatch($sformatf("weighted_sum expected %h got %h",
                                            want.weighted_sum, rsp_weighted_sum));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status expected %b got %b",
                                            want.status, rsp_status));
            end
         end
      end
      outstanding <= expected_sums_q.size();
      fail_count  <= mismatches;
   end

endmodule

FILE: tb/sv/dual_fenwick_weighted_prefix_sum_tb.sv
module dual_fenwick_weighted_prefix_sum_tb;
   import dfwps_pkg::*;

   localparam int TREE_SIZE = 4096;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 485;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [KIND_WIDTH-1:0]         req_kind = '0;
   logic [POS_WIDTH-1:0]          req_position = '0;
   logic signed [DELTA_WIDTH-1:0] req_delta = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SUM_WIDTH-1:0]   rsp_count_sum;
   logic signed [SUM_WIDTH-1:0]   rsp_weighted_sum;
   logic                          rsp_status;
   int                            fail_count;
   int                            outstanding;
   int                            idle_pct = 0;
   int                            stall_pct = 0;
   int                            quiet_cycles = 0;

   dual_fenwick_weighted_prefix_sum #(.TREE_SIZE(TREE_SIZE)) dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_kind, .req_position, .req_delta,
      .rsp_valid, .rsp_ready, .rsp_count_sum, .rsp_weighted_sum, .rsp_status
   );

   dual_fenwick_weighted_prefix_sum_checker #(.TREE_SIZE(TREE_SIZE)) chk (
      .clock, .reset,
      .req_valid, .req_ready, .req_kind, .req_position, .req_delta,
      .rsp_valid, .rsp_ready, .rsp_count_sum, .rsp_weighted_sum, .rsp_status,
      .fail_count, .outstanding
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // nothing moving for this long means the block is stuck
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("** dual_fenwick_weighted_prefix_sum: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic [KIND_WIDTH-1:0] kind,
                            input logic [POS_WIDTH-1:0] pos,
                            input logic signed [DELTA_WIDTH-1:0] delta);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_delta    <= delta;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [KIND_WIDTH-1:0]         kind;
      logic [POS_WIDTH-1:0]          pos;
      logic signed [DELTA_WIDTH-1:0] delta;
      int                            pick;
      pick = $urandom_range(199);
      if (pick < 92)       kind = KIND_ADD;
      else if (pick < 190) kind = KIND_QUERY;
      else if (pick < 197) kind = KIND_UNUSED;
      else                 kind = KIND_CLEAR;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: pos = $urandom;
         5, 6:          pos = $urandom_range(15, 1);
         7:             pos = 12'd1 << $urandom_range(11);
         8:             pos = 12'hFFF - (12'd1 << $urandom_range(11)) + 12'd1;
         default:       pos = $urandom_range(1) ? 12'hFFF : 12'd0;
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: delta = $urandom;
         6, 7:             delta = $signed($urandom_range(16)) - 8;
         8:                delta = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default:          delta = -1;
      endcase
      send_item(kind, pos, delta);
   endtask

   int idle_tab[4]  = '{0, 81, 0, 13};
   int stall_tab[4] = '{0, 0, 81, 13};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(KIND_QUERY, 12'hFFF, 0);
      send_item(KIND_ADD, 12'd0, 32'sd77);          // position zero is flagged
      send_item(KIND_ADD, 12'd1, 32'sh7FFFFFFF);
      send_item(KIND_ADD, 12'hFFF, 32'sh80000000);
      send_item(KIND_ADD, 12'd2048, -1);
      send_item(KIND_ADD, 12'hFFF, 32'sh7FFFFFFF);
      send_item(KIND_ADD, 12'hAAA, 32'sh55555555);
      send_item(KIND_ADD, 12'h555, 32'shAAAAAAAA);
      send_item(KIND_QUERY, 12'd0, 32'sd5);
      send_item(KIND_QUERY, 12'd1, 0);
      send_item(KIND_QUERY, 12'd2047, 0);
      send_item(KIND_QUERY, 12'd2048, 0);
      send_item(KIND_QUERY, 12'hFFF, 0);
      send_item(KIND_UNUSED, 12'd300, 32'sd9);
      send_item(KIND_QUERY, 12'hFFF, 0);
      send_item(KIND_CLEAR, 12'd0, 0);
      send_item(KIND_QUERY, 12'hFFF, 0);
      send_item(KIND_ADD, 12'd3, 32'sd12);
      send_item(KIND_QUERY, 12'd4, 0);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_tab[ph];
         stall_pct = stall_tab[ph];
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("** dual_fenwick_weighted_prefix_sum: PASSED **");
      end else begin
         $display("** dual_fenwick_weighted_prefix_sum: FAILED **");
      end
      $finish;
   end

endmodule
